// ----- design/sht_pkg.sv -----
`default_nettype none
package sht_pkg;

  localparam logic [63:0] HASH_START = 64'd5381;
  localparam logic [8:0]  CAP_RESET  = 9'd50;

  localparam logic [1:0] OP_LOOKUP = 2'd0;
  localparam logic [1:0] OP_INSERT = 2'd1;
  localparam logic [1:0] OP_CLEAR  = 2'd2;
  localparam logic [1:0] OP_UNUSED = 2'd3;

  localparam logic [2:0] ST_FOUND     = 3'd0;
  localparam logic [2:0] ST_INSERTED  = 3'd1;
  localparam logic [2:0] ST_NOT_FOUND = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_TOO_LONG  = 3'd4;
  localparam logic [2:0] ST_CLEARED   = 3'd5;

  typedef enum logic [9:0] {
    S_CLR  = 10'b00_0000_0001,
    S_IDLE = 10'b00_0000_0010,
    S_DIV  = 10'b00_0000_0100,
    S_MRD  = 10'b00_0000_1000,
    S_MCHK = 10'b00_0001_0000,
    S_CRD  = 10'b00_0010_0000,
    S_CCHK = 10'b00_0100_0000,
    S_CPR  = 10'b00_1000_0000,
    S_CPW  = 10'b01_0000_0000,
    S_EMIT = 10'b10_0000_0000
  } sht_state_t;

  typedef struct packed {
    logic start;
    logic busy;
    logic done;
  } sht_mod_ctl_t;

endpackage
`default_nettype wire

// ----- design/sht_ram.sv -----
`default_nettype none
module sht_ram #(
  parameter int W = 8,
  parameter int D = 256
) (
  input  wire logic                 clk,
  input  wire logic                 we,
  input  wire logic [$clog2(D)-1:0] waddr,
  input  wire logic [W-1:0]         wdata,
  input  wire logic [$clog2(D)-1:0] raddr,
  output logic      [W-1:0]         rdata
);

  logic [W-1:0] mem [D];
  logic [W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

// ----- design/sht_mod.sv -----
`default_nettype none
module sht_mod #(
  parameter int CW = 9
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  start,
  input  wire logic [63:0]           dividend,
  input  wire logic [CW-1:0]         divisor,
  output sht_pkg::sht_mod_ctl_t      ctl,
  output logic      [CW-1:0]         rem
);

  logic [63:0]   quot_r, quot_nxt;
  logic [CW-1:0] rem_r, rem_nxt;
  logic [CW-1:0] div_r;
  logic [5:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [CW:0]   trial;

  assign trial = {rem_r, quot_r[63]};

  always_comb begin
    quot_nxt = quot_r;
    rem_nxt  = rem_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    if (start) begin
      quot_nxt = dividend;
      rem_nxt  = '0;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      quot_nxt = {quot_r[62:0], 1'b0};
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = CW'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[CW-1:0];
      end
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == 6'd63) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    quot_r <= quot_nxt;
    rem_r  <= rem_nxt;
    if (start) begin
      div_r <= divisor;
    end
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign ctl.done  = done_r;
  assign rem       = rem_r;

endmodule
`default_nettype wire

// ----- design/string_hash_table_linear_probe_core.sv -----
`default_nettype none
// Channel  Direction  Handshake           Payload
// in       input      in_valid/in_stall   in_operation, in_key_char, in_key_last
// out      output     out_valid/out_stall out_slot_index, out_status, out_occupied_count
// cfg      input      cfg_wr_en           cfg_wr_data (active_capacity)
// A character transaction that is not the last leaves the core idle, ready for the next character.
// A final character then waits on the remainder unit for the start slot; each probe then reads
// and checks the slot metadata and compares the key byte by byte, and an insert copies the key bytes.
// Reset and clear run a pass over all TABLE_SLOTS slots of the slot memory.
// The result waits in an output register while out_stall is high.
module string_hash_table_linear_probe_core #(
  parameter int TABLE_SLOTS = 256,
  parameter int MAX_KEY_LEN = 32
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] in_operation,
  input  wire logic [7:0] in_key_char,
  input  wire logic       in_key_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_slot_index,
  output logic [2:0]      out_status,
  output logic [8:0]      out_occupied_count,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data
);

  localparam int SW = $clog2(TABLE_SLOTS);
  localparam int KW = $clog2(MAX_KEY_LEN);
  localparam int LW = $clog2(MAX_KEY_LEN + 2);
  localparam int CW = $clog2(TABLE_SLOTS + 1);

  sht_pkg::sht_state_t state_r, state_nxt;

  logic [63:0]   hash_r, hash_nxt, hash_upd;
  logic [LW-1:0] plen_r, plen_nxt, plen_upd;
  logic [LW-1:0] len_r, len_nxt;
  logic [1:0]    op_r, op_nxt;
  logic [CW-1:0] cap_r, cap_nxt, cap_eff;
  logic [SW-1:0] idx_r, idx_nxt, idx_adv;
  logic [CW-1:0] probe_r, probe_nxt;
  logic [KW-1:0] j_r, j_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [8:0]    cfg_r;
  logic [SW-1:0] clr_r, clr_nxt;
  logic          clr_emit_r, clr_emit_nxt;
  logic [SW-1:0] res_slot_r, res_slot_nxt;
  logic [2:0]    res_st_r, res_st_nxt;
  logic          out_valid_r, out_valid_nxt;
  logic [7:0]    out_slot_r, out_slot_nxt;
  logic [2:0]    out_st_r, out_st_nxt;
  logic [8:0]    out_cnt_r, out_cnt_nxt;

  logic          accept, j_last, adv_end;
  logic          div_start;
  sht_pkg::sht_mod_ctl_t div_ctl;
  logic [CW-1:0] div_rem;

  logic          pend_we;
  logic [7:0]    pend_rdata;
  logic          key_we;
  logic [7:0]    key_rdata;
  logic          meta_we;
  logic [SW-1:0] meta_waddr;
  logic [LW:0]   meta_wdata, meta_rdata;

  assign accept   = in_valid && !in_stall;
  assign in_stall = (state_r != sht_pkg::S_IDLE);

  always_comb begin
    if (cfg_r == 9'd0) begin
      cap_eff = CW'(1);
    end else if (int'(cfg_r) > TABLE_SLOTS) begin
      cap_eff = CW'(TABLE_SLOTS);
    end else begin
      cap_eff = CW'(cfg_r);
    end
  end

  assign hash_upd = (hash_r << 5) + hash_r + {56'd0, in_key_char};
  assign plen_upd = (int'(plen_r) <= MAX_KEY_LEN) ? plen_r + LW'(1) : plen_r;
  assign j_last   = (int'(j_r) == int'(len_r) - 1);
  assign idx_adv  = (CW'(idx_r) + CW'(1) == cap_r) ? '0 : idx_r + SW'(1);
  assign adv_end  = (probe_r + CW'(1) == cap_r);

  always_comb begin
    state_nxt     = state_r;
    hash_nxt      = hash_r;
    plen_nxt      = plen_r;
    len_nxt       = len_r;
    op_nxt        = op_r;
    cap_nxt       = cap_r;
    idx_nxt       = idx_r;
    probe_nxt     = probe_r;
    j_nxt         = j_r;
    cnt_nxt       = cnt_r;
    clr_nxt       = clr_r;
    clr_emit_nxt  = clr_emit_r;
    res_slot_nxt  = res_slot_r;
    res_st_nxt    = res_st_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_slot_nxt  = out_slot_r;
    out_st_nxt    = out_st_r;
    out_cnt_nxt   = out_cnt_r;
    div_start     = 1'b0;
    pend_we       = 1'b0;
    key_we        = 1'b0;
    meta_we       = 1'b0;
    meta_waddr    = idx_r;
    meta_wdata    = {1'b1, len_r};
    case (state_r)
      sht_pkg::S_CLR: begin
        meta_we    = 1'b1;
        meta_waddr = clr_r;
        meta_wdata = '0;
        clr_nxt    = clr_r + SW'(1);
        if (int'(clr_r) == TABLE_SLOTS - 1) begin
          cnt_nxt    = '0;
          res_slot_nxt = '0;
          res_st_nxt = sht_pkg::ST_CLEARED;
          state_nxt  = clr_emit_r ? sht_pkg::S_EMIT : sht_pkg::S_IDLE;
        end
      end
      sht_pkg::S_IDLE: begin
        if (accept) begin
          if (in_operation == sht_pkg::OP_CLEAR) begin
            hash_nxt     = sht_pkg::HASH_START;
            plen_nxt     = '0;
            clr_nxt      = '0;
            clr_emit_nxt = 1'b1;
            state_nxt    = sht_pkg::S_CLR;
          end else if (in_operation == sht_pkg::OP_LOOKUP ||
                       in_operation == sht_pkg::OP_INSERT) begin
            pend_we  = (int'(plen_r) < MAX_KEY_LEN);
            hash_nxt = hash_upd;
            plen_nxt = plen_upd;
            if (in_key_last) begin
              hash_nxt = sht_pkg::HASH_START;
              plen_nxt = '0;
              len_nxt  = plen_upd;
              op_nxt   = in_operation;
              cap_nxt  = cap_eff;
              if (int'(plen_upd) > MAX_KEY_LEN) begin
                res_slot_nxt = '0;
                res_st_nxt   = sht_pkg::ST_TOO_LONG;
                state_nxt    = sht_pkg::S_EMIT;
              end else begin
                div_start = 1'b1;
                state_nxt = sht_pkg::S_DIV;
              end
            end
          end
        end
      end
      sht_pkg::S_DIV: begin
        if (div_ctl.done) begin
          idx_nxt   = div_rem[SW-1:0];
          probe_nxt = '0;
          state_nxt = sht_pkg::S_MRD;
        end
      end
      sht_pkg::S_MRD: begin
        state_nxt = sht_pkg::S_MCHK;
      end
      sht_pkg::S_MCHK: begin
        j_nxt = '0;
        if (!meta_rdata[LW]) begin
          if (op_r == sht_pkg::OP_LOOKUP) begin
            res_slot_nxt = '0;
            res_st_nxt   = sht_pkg::ST_NOT_FOUND;
            state_nxt    = sht_pkg::S_EMIT;
          end else begin
            state_nxt = sht_pkg::S_CPR;
          end
        end else if (meta_rdata[LW-1:0] == len_r) begin
          state_nxt = sht_pkg::S_CRD;
        end else begin
          idx_nxt   = idx_adv;
          probe_nxt = probe_r + CW'(1);
          state_nxt = sht_pkg::S_MRD;
          if (adv_end) begin
            res_slot_nxt = '0;
            res_st_nxt   = (op_r == sht_pkg::OP_LOOKUP) ? sht_pkg::ST_NOT_FOUND
                                                        : sht_pkg::ST_FULL;
            state_nxt    = sht_pkg::S_EMIT;
          end
        end
      end
      sht_pkg::S_CRD: begin
        state_nxt = sht_pkg::S_CCHK;
      end
      sht_pkg::S_CCHK: begin
        if (key_rdata != pend_rdata) begin
          idx_nxt   = idx_adv;
          probe_nxt = probe_r + CW'(1);
          state_nxt = sht_pkg::S_MRD;
          if (adv_end) begin
            res_slot_nxt = '0;
            res_st_nxt   = (op_r == sht_pkg::OP_LOOKUP) ? sht_pkg::ST_NOT_FOUND
                                                        : sht_pkg::ST_FULL;
            state_nxt    = sht_pkg::S_EMIT;
          end
        end else if (j_last) begin
          res_slot_nxt = idx_r;
          res_st_nxt   = sht_pkg::ST_FOUND;
          state_nxt    = sht_pkg::S_EMIT;
        end else begin
          j_nxt     = j_r + KW'(1);
          state_nxt = sht_pkg::S_CRD;
        end
      end
      sht_pkg::S_CPR: begin
        state_nxt = sht_pkg::S_CPW;
      end
      sht_pkg::S_CPW: begin
        key_we = 1'b1;
        if (j_last) begin
          meta_we      = 1'b1;
          cnt_nxt      = cnt_r + CW'(1);
          res_slot_nxt = idx_r;
          res_st_nxt   = sht_pkg::ST_INSERTED;
          state_nxt    = sht_pkg::S_EMIT;
        end else begin
          j_nxt     = j_r + KW'(1);
          state_nxt = sht_pkg::S_CPR;
        end
      end
      sht_pkg::S_EMIT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_slot_nxt  = 8'(res_slot_r);
          out_st_nxt    = res_st_r;
          out_cnt_nxt   = 9'(cnt_r);
          clr_emit_nxt  = 1'b0;
          state_nxt     = sht_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = sht_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= sht_pkg::S_CLR;
      hash_r      <= sht_pkg::HASH_START;
      plen_r      <= '0;
      cnt_r       <= '0;
      cfg_r       <= sht_pkg::CAP_RESET;
      clr_r       <= '0;
      clr_emit_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      hash_r      <= hash_nxt;
      plen_r      <= plen_nxt;
      cnt_r       <= cnt_nxt;
      clr_r       <= clr_nxt;
      clr_emit_r  <= clr_emit_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
    len_r      <= len_nxt;
    op_r       <= op_nxt;
    cap_r      <= cap_nxt;
    idx_r      <= idx_nxt;
    probe_r    <= probe_nxt;
    j_r        <= j_nxt;
    res_slot_r <= res_slot_nxt;
    res_st_r   <= res_st_nxt;
    out_slot_r <= out_slot_nxt;
    out_st_r   <= out_st_nxt;
    out_cnt_r  <= out_cnt_nxt;
  end

  sht_mod #(.CW(CW)) u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (hash_upd),
    .divisor  (cap_eff),
    .ctl      (div_ctl),
    .rem      (div_rem)
  );

  sht_ram #(.W(8), .D(MAX_KEY_LEN)) u_pend (
    .clk   (clk),
    .we    (pend_we),
    .waddr (plen_r[KW-1:0]),
    .wdata (in_key_char),
    .raddr (j_r),
    .rdata (pend_rdata)
  );

  sht_ram #(.W(8), .D(TABLE_SLOTS << KW)) u_keys (
    .clk   (clk),
    .we    (key_we),
    .waddr ({idx_r, j_r}),
    .wdata (pend_rdata),
    .raddr ({idx_r, j_r}),
    .rdata (key_rdata)
  );

  sht_ram #(.W(LW + 1), .D(TABLE_SLOTS)) u_meta (
    .clk   (clk),
    .we    (meta_we),
    .waddr (meta_waddr),
    .wdata (meta_wdata),
    .raddr (idx_r),
    .rdata (meta_rdata)
  );

  assign out_valid          = out_valid_r;
  assign out_slot_index     = out_slot_r;
  assign out_status         = out_st_r;
  assign out_occupied_count = out_cnt_r;

endmodule
`default_nettype wire

// ----- design/sht_checker.sv -----
`default_nettype none
module sht_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_stall,
  input wire logic [1:0] in_operation,
  input wire logic [7:0] in_key_char,
  input wire logic       in_key_last,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [7:0] out_slot_index,
  input wire logic [2:0] out_status,
  input wire logic [8:0] out_occupied_count,
  input wire logic       cfg_wr_en,
  input wire logic [8:0] cfg_wr_data
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_status))
    else $error("Stalled result transaction was dropped or changed.");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_status <= sht_pkg::ST_CLEARED)
    else $error("Result status code out of range.");

  a_slot_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status != sht_pkg::ST_FOUND && out_status != sht_pkg::ST_INSERTED
    |-> out_slot_index == 8'd0)
    else $error("Slot index must be zero without a hit.");

  a_clear_count: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_status == sht_pkg::ST_CLEARED |-> out_occupied_count == 9'd0)
    else $error("Clear result must report an empty table.");

endmodule

bind string_hash_table_linear_probe_core sht_checker u_sht_checker (.*);
`default_nettype wire
